FILE: design/hilbert_curve_move_generator_unit_assert.svh
// assertion macros for the hilbert curve move generator
`ifndef HILBERT_CURVE_MOVE_GENERATOR_UNIT_ASSERT_SVH
`define HILBERT_CURVE_MOVE_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define HCMG_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HCMG_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/hcmg_pkg.sv
// shared types, constants and tables of the hilbert curve move generator
package hcmg_pkg;

  localparam int ORDER_MAX = 8;
  localparam int ORDER_W   = 4;
  localparam int IDX_W     = 16;
  localparam int POS_W     = 8;
  localparam int LEVEL_W   = 3;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_MOVE = 3'b100
  } state_t;

  typedef enum logic [1:0] {
    DIR_PX = 2'd0,
    DIR_PY = 2'd1,
    DIR_NX = 2'd2,
    DIR_NY = 2'd3
  } dir_t;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic out_free;
  } stat_t;

  // sub-curve type per digit, rows are types a..d
  localparam logic [1:0] SUB_TYPE [4][4] = '{
    '{2'd3, 2'd0, 2'd0, 2'd1},
    '{2'd2, 2'd1, 2'd1, 2'd0},
    '{2'd1, 2'd2, 2'd2, 2'd3},
    '{2'd0, 2'd3, 2'd3, 2'd2}
  };

  // connector heading per type, for digits 1..3
  localparam logic [1:0] JOINT_DIR [4][3] = '{
    '{2'd2, 2'd3, 2'd0},
    '{2'd1, 2'd0, 2'd3},
    '{2'd0, 2'd1, 2'd2},
    '{2'd3, 2'd2, 2'd1}
  };

  function automatic logic [ORDER_W-1:0] clamp_order(input logic [ORDER_W-1:0] v);
    logic [ORDER_W-1:0] r;
    if (v == '0) begin
      r = ORDER_W'(1);
    end else if (v > ORDER_W'(ORDER_MAX)) begin
      r = ORDER_W'(ORDER_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // 2^n - 1
  function automatic logic [POS_W-1:0] corner(input logic [ORDER_W-1:0] n);
    logic [POS_W:0] c;
    c = ((POS_W+1)'(1) << n) - (POS_W+1)'(1);
    return c[POS_W-1:0];
  endfunction

  // index of the final move, 4^n - 2
  function automatic logic [IDX_W-1:0] final_index(input logic [ORDER_W-1:0] n);
    logic [IDX_W:0] f;
    f = ((IDX_W+1)'(1) << {n, 1'b0}) - (IDX_W+1)'(2);
    return f[IDX_W-1:0];
  endfunction

endpackage

FILE: design/hcmg_ctrl.sv
// controller of the hilbert curve move generator
module hcmg_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  hcmg_pkg::stat_t stat,
  output hcmg_pkg::cmd_t  cmd
);

  hcmg_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hcmg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.start  = 1'b0;
    cmd.step   = 1'b0;
    cmd.commit = 1'b0;
    in_ready   = 1'b0;
    cfg_ready  = 1'b0;
    case (state_r)
      hcmg_pkg::ST_IDLE: begin
        cfg_ready = 1'b1;
        cmd.load  = cfg_valid;
        // a register write takes the cycle, the input beat waits
        in_ready  = !cfg_valid;
        cmd.start = in_valid && !cfg_valid;
        if (in_valid && !cfg_valid) begin
          state_nxt = hcmg_pkg::ST_WALK;
        end
      end
      hcmg_pkg::ST_WALK: begin
        cmd.step = 1'b1;
        if (stat.found) begin
          state_nxt = hcmg_pkg::ST_MOVE;
        end
      end
      hcmg_pkg::ST_MOVE: begin
        // wait here while the previous result is still held
        cmd.commit = stat.out_free;
        if (stat.out_free) begin
          state_nxt = hcmg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hcmg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/hcmg_dp.sv
// datapath of the hilbert curve move generator: digit walk, position and result register
module hcmg_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  hcmg_pkg::cmd_t                  cmd,
  output hcmg_pkg::stat_t                 stat,
  input  logic                            in_restart,
  input  logic [hcmg_pkg::ORDER_W-1:0]    cfg_curve_order,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [1:0]                      out_direction,
  output logic [hcmg_pkg::POS_W-1:0]      out_pos_x,
  output logic [hcmg_pkg::POS_W-1:0]      out_pos_y,
  output logic                            out_last
);

  logic [hcmg_pkg::ORDER_W-1:0] order_r, order_nxt;
  logic [hcmg_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic [hcmg_pkg::POS_W-1:0]   x_r, x_nxt, y_r, y_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [hcmg_pkg::LEVEL_W-1:0] level_r, level_nxt;
  logic [1:0]                   type_r, type_nxt;
  logic [1:0]                   dir_r, dir_nxt;
  logic [1:0]                   out_dir_r, out_dir_nxt;
  logic [hcmg_pkg::POS_W-1:0]   out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic                         out_last_r, out_last_nxt;

  logic [hcmg_pkg::IDX_W-1:0]   t;
  logic [hcmg_pkg::LEVEL_W:0]   sh;
  logic [hcmg_pkg::IDX_W-1:0]   low_mask;
  logic [1:0]                   digit;
  logic                         low_zero;
  logic                         hit;
  logic [1:0]                   joint_sel;
  logic [hcmg_pkg::POS_W-1:0]   mx, my;
  logic                         is_last;
  logic [hcmg_pkg::ORDER_W-1:0] cfg_order;

  assign t        = idx_r + hcmg_pkg::IDX_W'(1);
  assign sh       = {level_r, 1'b0};
  assign digit    = 2'(t >> sh);
  assign low_mask = (hcmg_pkg::IDX_W'(1) << sh) - hcmg_pkg::IDX_W'(1);
  assign low_zero = ((t & low_mask) == '0);
  // lowest nonzero digit reached, or bottom level as a backstop
  assign hit      = (low_zero && (digit != 2'd0)) || (level_r == '0);
  assign joint_sel = (digit == 2'd0) ? 2'd0 : (digit - 2'd1);
  assign cfg_order = hcmg_pkg::clamp_order(cfg_curve_order);
  assign is_last   = (idx_r >= hcmg_pkg::final_index(order_r));

  always_comb begin
    mx = x_r;
    my = y_r;
    case (hcmg_pkg::dir_t'(dir_r))
      hcmg_pkg::DIR_PX: mx = x_r + hcmg_pkg::POS_W'(1);
      hcmg_pkg::DIR_PY: my = y_r + hcmg_pkg::POS_W'(1);
      hcmg_pkg::DIR_NX: mx = x_r - hcmg_pkg::POS_W'(1);
      hcmg_pkg::DIR_NY: my = y_r - hcmg_pkg::POS_W'(1);
      default: begin
        mx = x_r;
        my = y_r;
      end
    endcase
  end

  always_comb begin
    order_nxt     = order_r;
    idx_nxt       = idx_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    level_nxt     = level_r;
    type_nxt      = type_r;
    dir_nxt       = dir_r;
    out_dir_nxt   = out_dir_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.load) begin
      order_nxt = cfg_order;
      idx_nxt   = '0;
      x_nxt     = hcmg_pkg::corner(cfg_order);
      y_nxt     = hcmg_pkg::corner(cfg_order);
    end else if (cmd.start) begin
      if (in_restart) begin
        idx_nxt = '0;
        x_nxt   = hcmg_pkg::corner(order_r);
        y_nxt   = hcmg_pkg::corner(order_r);
      end
      level_nxt = hcmg_pkg::LEVEL_W'(order_r - hcmg_pkg::ORDER_W'(1));
      type_nxt  = 2'd0;
    end else if (cmd.step) begin
      if (hit) begin
        dir_nxt = hcmg_pkg::JOINT_DIR[type_r][joint_sel];
      end else begin
        type_nxt  = hcmg_pkg::SUB_TYPE[type_r][digit];
        level_nxt = level_r - hcmg_pkg::LEVEL_W'(1);
      end
    end else if (cmd.commit) begin
      out_valid_nxt = 1'b1;
      out_dir_nxt   = dir_r;
      out_x_nxt     = mx;
      out_y_nxt     = my;
      out_last_nxt  = is_last;
      if (is_last) begin
        idx_nxt = '0;
        x_nxt   = hcmg_pkg::corner(order_r);
        y_nxt   = hcmg_pkg::corner(order_r);
      end else begin
        idx_nxt = idx_r + hcmg_pkg::IDX_W'(1);
        x_nxt   = mx;
        y_nxt   = my;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r     <= hcmg_pkg::ORDER_W'(1);
      idx_r       <= '0;
      x_r         <= hcmg_pkg::corner(hcmg_pkg::ORDER_W'(1));
      y_r         <= hcmg_pkg::corner(hcmg_pkg::ORDER_W'(1));
      out_valid_r <= 1'b0;
    end else begin
      order_r     <= order_nxt;
      idx_r       <= idx_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    level_r    <= level_nxt;
    type_r     <= type_nxt;
    dir_r      <= dir_nxt;
    out_dir_r  <= out_dir_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_last_r <= out_last_nxt;
  end

  assign stat.found    = hit;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_direction = out_dir_r;
  assign out_pos_x     = out_x_r;
  assign out_pos_y     = out_y_r;
  assign out_last      = out_last_r;

endmodule

FILE: design/hilbert_curve_move_generator_unit.sv
// top level of the hilbert curve move generator
//
// each input beat (in_restart) produces one output beat: the heading of the
// next unit move of the curve, the grid position after it, and a flag on the
// final move of the curve. in_restart=1 starts over from the corner
// (2^n-1, 2^n-1); after the final move the curve starts over by itself.
// cfg_curve_order sets the order n (0 reads as 1, above 8 reads as 8) and
// restarts the curve; cfg_ready is high only while the block is idle, and a
// write there holds off an input beat offered in the same cycle.
// an item goes from acceptance to output valid through these steps: the accept,
// a walk over the base-4 digits of the move index from the top down to the
// lowest nonzero digit, and the move step that applies the move. the digit
// walk is the limit on throughput.
// the result sits in an output register, so the next beat is accepted while
// a result waits; a stalled receiver holds the next result in the move step.
// synchronous active-low reset: order 1, position (1,1), move index 0, no
// result pending.
module hilbert_curve_move_generator_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_restart,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_direction,
  output logic [hcmg_pkg::POS_W-1:0]   out_pos_x,
  output logic [hcmg_pkg::POS_W-1:0]   out_pos_y,
  output logic                         out_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [hcmg_pkg::ORDER_W-1:0] cfg_curve_order
);

  hcmg_pkg::cmd_t  cmd;
  hcmg_pkg::stat_t stat;

  hcmg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hcmg_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_restart      (in_restart),
    .cfg_curve_order (cfg_curve_order),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_direction   (out_direction),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_last        (out_last)
  );

`include "hilbert_curve_move_generator_unit_assert.svh"

  `HCMG_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "busy")
  `HCMG_ASSERT_NXT(a_commit_shows_result, clk, rst_n, cmd.commit, out_valid, "commit lost")
  `HCMG_ASSERT_IMP(a_result_from_move, clk, rst_n, $rose(out_valid), !$past(in_ready), "from idle")

endmodule

FILE: sim/tb.sv
// testbench for the hilbert curve move generator: directed and random moves checked against a predictor
module tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_CNT = 15;

  // child curve kind per base-4 digit, rows are kinds a..d
  localparam logic [1:0] CHILD_KIND [4][4] = '{
    '{2'd3, 2'd0, 2'd0, 2'd1},
    '{2'd2, 2'd1, 2'd1, 2'd0},
    '{2'd1, 2'd2, 2'd2, 2'd3},
    '{2'd0, 2'd3, 2'd3, 2'd2}
  };

  // heading of the joining step per kind, for digits 1..3
  localparam logic [1:0] LINK_HEADING [4][3] = '{
    '{2'd2, 2'd3, 2'd0},
    '{2'd1, 2'd0, 2'd3},
    '{2'd0, 2'd1, 2'd2},
    '{2'd3, 2'd2, 2'd1}
  };

  // order written per random phase, with beat counts and restart odds
  localparam logic [hcmg_pkg::ORDER_W-1:0] PHASE_ORDER [PHASE_CNT] = '{
    4'd2, 4'd3, 4'd8, 4'd4, 4'd5, 4'd6, 4'd7, 4'd1,
    4'd10, 4'd11, 4'd12, 4'd13, 4'd0, 4'd15, 4'd3
  };
  localparam int PHASE_ITEMS [PHASE_CNT] = '{
    120, 150, 100, 300, 100, 80, 80, 60,
    60, 40, 40, 40, 40, 100, 270
  };
  localparam int PHASE_RESTART_PCT [PHASE_CNT] = '{
    3, 3, 3, 0, 2, 2, 2, 5,
    3, 3, 3, 3, 5, 30, 2
  };

  typedef struct packed {
    hcmg_pkg::dir_t             dir;
    logic [hcmg_pkg::POS_W-1:0] px;
    logic [hcmg_pkg::POS_W-1:0] py;
    logic                       last;
  } move_t;

  class move_scoreboard;
    logic [hcmg_pkg::ORDER_W-1:0] order_reg;
    int                           move_idx;
    logic [hcmg_pkg::POS_W-1:0]   cur_x;
    logic [hcmg_pkg::POS_W-1:0]   cur_y;
    move_t                        expected_moves [$];
    int                           checked;
    int                           final_moves;
    int                           restarts;
    int                           order_writes;
    int                           mismatches;
    int                           unexpected;
    int                           reported;

    function new();
      order_reg = hcmg_pkg::ORDER_W'(1);
      go_corner();
    endfunction

    function int eff_order();
      if (order_reg == 0) return 1;
      if (order_reg > hcmg_pkg::ORDER_MAX) return hcmg_pkg::ORDER_MAX;
      return order_reg;
    endfunction

    function void go_corner();
      move_idx = 0;
      cur_x = hcmg_pkg::POS_W'((1 << eff_order()) - 1);
      cur_y = cur_x;
    endfunction

    function void set_order(logic [hcmg_pkg::ORDER_W-1:0] v);
      order_reg = v;
      order_writes++;
      go_corner();
    endfunction

    // walk base-4 digits of move+1 from the top down to the lowest nonzero one
    function hcmg_pkg::dir_t heading(int n, int m);
      int t;
      int kind;
      int k;
      int sh;
      int d;
      t = m + 1;
      kind = 0;
      for (k = n - 1; k >= 0; k--) begin
        sh = 2 * k;
        d = (t >> sh) & 3;
        if ((t & ((1 << sh) - 1)) == 0 && d != 0)
          return hcmg_pkg::dir_t'(LINK_HEADING[kind][d-1]);
        kind = CHILD_KIND[kind][d];
      end
      return hcmg_pkg::DIR_PX;
    endfunction

    function void note_move(bit restart);
      int    n;
      move_t e;
      n = eff_order();
      if (restart) begin
        go_corner();
        restarts++;
      end
      e.dir = heading(n, move_idx);
      case (e.dir)
        hcmg_pkg::DIR_PX: cur_x = cur_x + 1'b1;
        hcmg_pkg::DIR_PY: cur_y = cur_y + 1'b1;
        hcmg_pkg::DIR_NX: cur_x = cur_x - 1'b1;
        default: cur_y = cur_y - 1'b1;
      endcase
      e.px = cur_x;
      e.py = cur_y;
      e.last = (move_idx >= (1 << (2 * n)) - 2);
      expected_moves.push_back(e);
      if (e.last) begin
        go_corner();
      end else begin
        move_idx++;
      end
    endfunction

    function void check_move(logic [1:0] dir, logic [hcmg_pkg::POS_W-1:0] px,
                             logic [hcmg_pkg::POS_W-1:0] py, logic last);
      move_t e;
      if (expected_moves.size() == 0) begin
        unexpected++;
        reported++;
        if (reported <= 10)
          $display("unexpected result beat: dir=%0d x=%0d y=%0d last=%0b", dir, px, py, last);
        return;
      end
      e = expected_moves.pop_front();
      checked++;
      if (e.last) final_moves++;
      if (dir !== e.dir || px !== e.px || py !== e.py || last !== e.last) begin
        mismatches++;
        reported++;
        if (reported <= 10)
          $display("move %0d mismatch: exp dir=%0d x=%0d y=%0d last=%0b,",
                   checked, e.dir, e.px, e.py, e.last,
                   " got dir=%0d x=%0d y=%0d last=%0b", dir, px, py, last);
      end
    endfunction

    function int pending();
      return expected_moves.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           in_restart = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [1:0]                     out_direction;
  logic [hcmg_pkg::POS_W-1:0]     out_pos_x;
  logic [hcmg_pkg::POS_W-1:0]     out_pos_y;
  logic                           out_last;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [hcmg_pkg::ORDER_W-1:0]   cfg_curve_order = '0;

  move_scoreboard sb = new();
  bit             quiet = 1'b0;
  int             stall_left = 0;
  int             cycle_count = 0;

  hilbert_curve_move_generator_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_direction   (out_direction),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_curve_order (cfg_curve_order)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d moves outstanding", cycle_count, sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side: check accepted beats, then choose ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_move(out_direction, out_pos_x, out_pos_y, out_last);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(99) < 25) begin
      stall_left <= pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_move(bit restart);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    sb.note_move(restart);
  endtask

  task automatic send_pattern(logic [15:0] bits, int n);
    int i;
    for (i = 0; i < n; i++) send_move(bits[i]);
    in_valid <= 1'b0;
  endtask

  task automatic write_order(logic [hcmg_pkg::ORDER_W-1:0] v);
    while (sb.pending() != 0) @(posedge clk);
    // let the digit walk settle before touching the order
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_curve_order <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_order(v);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int items, int restart_pct);
    int i;
    for (i = 0; i < items; i++) send_move($urandom_range(99) < restart_pct);
    in_valid <= 1'b0;
  endtask

  initial begin
    int p;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset order: whole curve, wrap, restart mid curve, whole curve again
    send_pattern(16'b0000_0000_0001_0000, 8);
    // zero reads as order 1
    write_order(4'd0);
    send_pattern(16'b0, 4);
    // all ones reads as the top order
    write_order(4'd15);
    send_pattern(16'b0000_0000_0010_0001, 6);
    write_order(4'd9);
    send_pattern(16'b0, 3);

    for (p = 0; p < PHASE_CNT; p++) begin
      write_order(PHASE_ORDER[p]);
      quiet = (p % 4 == 1);
      run_phase(PHASE_ITEMS[p], PHASE_RESTART_PCT[p]);
    end
    quiet = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d moves checked over %0d order writes, %0d restarts, %0d curve ends",
             sb.checked, sb.order_writes, sb.restarts, sb.final_moves);
    $display("mismatches %0d, unexpected beats %0d", sb.mismatches, sb.unexpected);
    if (sb.mismatches == 0 && sb.unexpected == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
